### sv/tcce_pkg.sv
package tcce_pkg;

    // Command selector carried in the input tuser field.
    localparam logic [1:0] MODE_CHAR    = 2'd0;
    localparam logic [1:0] MODE_SET     = 2'd1;
    localparam logic [1:0] MODE_SAVE    = 2'd2;
    localparam logic [1:0] MODE_RESTORE = 2'd3;

    // Character codes with a cursor action of their own.
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_DEL   = 8'd127;

    // Glyphs sent to the renderer.
    localparam logic [6:0] GLYPH_SPACE = 7'd32;
    localparam logic [6:0] GLYPH_QMARK = 7'd63;

    // Configuration register indexes.
    localparam logic CFG_NUM_COLS = 1'b0;
    localparam logic CFG_NUM_ROWS = 1'b1;

    // Reset values of the screen size registers.
    localparam logic [8:0] COLS_RESET = 9'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;

    // Fixed widths of the stream fields.
    localparam int FIELD_COL_W = 9;
    localparam int FIELD_ROW_W = 8;

    // Result of one item before it is packed onto the output stream.
    typedef struct packed {
        logic                   draw_valid;
        logic [FIELD_COL_W-1:0] draw_col;
        logic [FIELD_ROW_W-1:0] draw_row;
        logic [6:0]             glyph_code;
        logic                   scroll_req;
        logic [FIELD_COL_W-1:0] cursor_col_now;
        logic [FIELD_ROW_W-1:0] cursor_row_now;
    } t_result;

endpackage

### sv/text_console_cursor_engine_unit.sv
// Each item passes through the input register, then the result register, before
// its result is presented; items that are pure commands produce a result just the same.
// Throughput: one item per cycle while results are taken, set by the cursor update loop.
// Reset (i_rst_n low, synchronous): cursor and saved cursor go to 0, the screen size
// returns to 80 columns by 25 rows, and both stream stages are emptied.
module text_console_cursor_engine_unit
    import tcce_pkg::*;
#(
    parameter int COL_BITS = 9,
    parameter int ROW_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration write port.
    input  logic        i_cfg_wen,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_wdata,

    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata, lowest bit up: char_code[7:0], set_col[16:8], set_row[24:17], zero[31:25].
    input  logic [31:0] i_s_tdata,
    // tuser: mode[1:0].
    input  logic [1:0]  i_s_tuser,

    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata, lowest bit up: draw_valid[0], draw_col[9:1], draw_row[17:10],
    // glyph_code[24:18], scroll_req[25], cursor_col_now[34:26], cursor_row_now[42:35],
    // zero[47:43].
    output logic [47:0] o_m_tdata
);

    // Working widths: wide enough for the stored position plus one step, and for the
    // screen size it is compared against, so no sum is truncated before the compare.
    localparam int CW = ((COL_BITS > FIELD_COL_W) ? COL_BITS : FIELD_COL_W) + 1;
    localparam int RW = ((ROW_BITS > FIELD_ROW_W) ? ROW_BITS : FIELD_ROW_W) + 1;

    // Screen size registers.
    logic [8:0] r_cols;
    logic [7:0] r_rows;

    // Cursor and saved cursor.
    logic [COL_BITS-1:0] r_cur_col, n_cur_col;
    logic [ROW_BITS-1:0] r_cur_row, n_cur_row;
    logic [COL_BITS-1:0] r_kept_col, n_kept_col;
    logic [ROW_BITS-1:0] r_kept_row, n_kept_row;

    // Input register.
    logic       r_in_valid;
    logic [1:0] r_mode;
    logic [7:0] r_code;
    logic [8:0] r_set_col;
    logic [7:0] r_set_row;

    // Result register.
    logic    r_out_valid;
    t_result r_res, n_res;

    // The result register moves whenever it is empty or its content is being taken;
    // the input register then hands its item over. The input register is refilled
    // in the same cycle it drains, so a result waiting downstream does not block a
    // new transfer into an empty input register.
    logic advance;
    logic in_take;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    // Cursor update for the item held in the input register.
    logic [8:0]    ncols;
    logic [7:0]    nrows;
    logic [CW-1:0] cur_col_x;
    logic [RW-1:0] cur_row_x;
    logic [CW-1:0] col_x;
    logic [RW-1:0] row_x;
    logic          check;
    logic          draw;
    logic          scroll;
    logic [CW-1:0] dcol_x;
    logic [RW-1:0] drow_x;
    logic [6:0]    glyph;

    always_comb begin
        // A zero screen size behaves as a size of one.
        ncols     = (r_cols == '0) ? 9'd1 : r_cols;
        nrows     = (r_rows == '0) ? 8'd1 : r_rows;
        cur_col_x = CW'(r_cur_col);
        cur_row_x = RW'(r_cur_row);
        col_x     = cur_col_x;
        row_x     = cur_row_x;
        check     = 1'b0;
        draw      = 1'b0;
        scroll    = 1'b0;
        dcol_x    = '0;
        drow_x    = '0;
        glyph     = GLYPH_SPACE;
        n_kept_col = r_kept_col;
        n_kept_row = r_kept_row;

        case (r_mode)
            MODE_SET: begin
                // Taken unchecked; it may lie off screen.
                col_x = CW'(r_set_col);
                row_x = RW'(r_set_row);
            end
            MODE_SAVE: begin
                n_kept_col = r_cur_col;
                n_kept_row = r_cur_row;
            end
            MODE_RESTORE: begin
                col_x = CW'(r_kept_col);
                row_x = RW'(r_kept_row);
            end
            default: begin
                case (r_code)
                    CHAR_LF: begin
                        col_x = '0;
                        row_x = cur_row_x + RW'(1);
                        check = 1'b1;
                    end
                    CHAR_CR: begin
                        col_x = '0;
                        check = 1'b1;
                    end
                    CHAR_TAB: begin
                        col_x = (cur_col_x + CW'(4)) & ~CW'(3);
                        check = 1'b1;
                    end
                    CHAR_BS: begin
                        // Backspace at the left edge does nothing; otherwise it
                        // erases the cell it lands on and never wraps or scrolls.
                        if (cur_col_x != '0) begin
                            col_x  = cur_col_x - CW'(1);
                            draw   = 1'b1;
                            dcol_x = cur_col_x - CW'(1);
                            drow_x = cur_row_x;
                        end
                    end
                    default: begin
                        if (r_code inside {[CHAR_SPACE:CHAR_DEL]}) begin
                            draw   = 1'b1;
                            dcol_x = cur_col_x;
                            drow_x = cur_row_x;
                            glyph  = (r_code == CHAR_DEL) ? GLYPH_QMARK : r_code[6:0];
                            col_x  = cur_col_x + CW'(1);
                            check  = 1'b1;
                        end
                    end
                endcase
            end
        endcase

        // Wrap past the right edge, then scroll past the bottom row.
        if (check) begin
            if (col_x >= CW'(ncols)) begin
                col_x = '0;
                row_x = row_x + RW'(1);
            end
            if (row_x >= RW'(nrows)) begin
                row_x  = RW'(nrows) - RW'(1);
                col_x  = '0;
                scroll = 1'b1;
            end
        end

        n_cur_col = col_x[COL_BITS-1:0];
        n_cur_row = row_x[ROW_BITS-1:0];

        n_res.draw_valid     = draw;
        n_res.draw_col       = dcol_x[FIELD_COL_W-1:0];
        n_res.draw_row       = drow_x[FIELD_ROW_W-1:0];
        n_res.glyph_code     = glyph;
        n_res.scroll_req     = scroll;
        n_res.cursor_col_now = FIELD_COL_W'(n_cur_col);
        n_res.cursor_row_now = FIELD_ROW_W'(n_cur_row);
    end

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                CFG_NUM_COLS: r_cols <= i_cfg_wdata;
                CFG_NUM_ROWS: r_rows <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Input register control and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode    <= i_s_tuser;
            r_code    <= i_s_tdata[7:0];
            r_set_col <= i_s_tdata[16:8];
            r_set_row <= i_s_tdata[24:17];
        end
    end

    // Cursor state advances once per item, as the item moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col  <= '0;
            r_cur_row  <= '0;
            r_kept_col <= '0;
            r_kept_row <= '0;
        end else if (r_in_valid && advance) begin
            r_cur_col  <= n_cur_col;
            r_cur_row  <= n_cur_row;
            r_kept_col <= n_kept_col;
            r_kept_row <= n_kept_row;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0,
                         r_res.cursor_row_now,
                         r_res.cursor_col_now,
                         r_res.scroll_req,
                         r_res.glyph_code,
                         r_res.draw_row,
                         r_res.draw_col,
                         r_res.draw_valid};

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tcce_pkg::*;

    // The watchdog ends the run here; even with the longest idle bursts on every item a
    // correct run needs well under a fifth of it.
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 220;

    // Scoreboard: it keeps its own copy of the cursor, the saved cursor and the screen size,
    // works out the result of every input transfer, and compares result transfers in order.
    class cursor_scoreboard;
        logic [8:0] num_cols;
        logic [7:0] num_rows;
        logic [8:0] cur_col;
        logic [7:0] cur_row;
        logic [8:0] kept_col;
        logic [7:0] kept_row;
        t_result    expected_results[$];
        int         mismatches;

        function new();
            num_cols    = COLS_RESET;
            num_rows    = ROWS_RESET;
            cur_col     = '0;
            cur_row     = '0;
            kept_col    = '0;
            kept_row    = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic index, logic [8:0] value);
            if (index == CFG_NUM_COLS) begin
                num_cols = value;
            end else begin
                num_rows = value[7:0];
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Advances the cursor for one accepted item and queues the result it must produce.
        function void note_item(logic [1:0] mode, logic [7:0] code,
                                logic [8:0] set_col, logic [7:0] set_row);
            int unsigned ncols;
            int unsigned nrows;
            int unsigned col;
            int unsigned row;
            bit          bound_check;
            t_result     res;
            ncols       = (num_cols == 0) ? 1 : num_cols;
            nrows       = (num_rows == 0) ? 1 : num_rows;
            col         = cur_col;
            row         = cur_row;
            bound_check = 1'b0;
            res         = '0;
            res.glyph_code = GLYPH_SPACE;
            case (mode)
                MODE_SET: begin
                    col = set_col;
                    row = set_row;
                end
                MODE_SAVE: begin
                    kept_col = cur_col;
                    kept_row = cur_row;
                end
                MODE_RESTORE: begin
                    col = kept_col;
                    row = kept_row;
                end
                default: begin
                    if (code == CHAR_LF) begin
                        col = 0;
                        row = row + 1;
                        bound_check = 1'b1;
                    end else if (code == CHAR_CR) begin
                        col = 0;
                        bound_check = 1'b1;
                    end else if (code == CHAR_TAB) begin
                        col = (col + 4) & ~32'd3;
                        bound_check = 1'b1;
                    end else if (code == CHAR_BS) begin
                        // Backspace erases the cell it lands on and never wraps or scrolls.
                        if (col > 0) begin
                            col = col - 1;
                            res.draw_valid = 1'b1;
                            res.draw_col   = col[8:0];
                            res.draw_row   = row[7:0];
                        end
                    end else if (code >= CHAR_SPACE && code <= CHAR_DEL) begin
                        res.draw_valid = 1'b1;
                        res.draw_col   = col[8:0];
                        res.draw_row   = row[7:0];
                        res.glyph_code = (code == CHAR_DEL) ? GLYPH_QMARK : code[6:0];
                        col = col + 1;
                        bound_check = 1'b1;
                    end
                end
            endcase
            // Sums are compared at full precision and only truncated when stored.
            if (bound_check) begin
                if (col >= ncols) begin
                    col = 0;
                    row = row + 1;
                end
                if (row >= nrows) begin
                    row = nrows - 1;
                    col = 0;
                    res.scroll_req = 1'b1;
                end
            end
            cur_col = col[8:0];
            cur_row = row[7:0];
            res.cursor_col_now = cur_col;
            res.cursor_row_now = cur_row;
            expected_results.push_back(res);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                end
            end
        endfunction

        function void check_result(logic [47:0] data);
            t_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result transfer with nothing expected, got %h", $time, data);
                end
                return;
            end
            want = expected_results.pop_front();
            check_field("draw_valid", want.draw_valid, data[0]);
            check_field("draw_col", want.draw_col, data[9:1]);
            check_field("draw_row", want.draw_row, data[17:10]);
            check_field("glyph_code", want.glyph_code, data[24:18]);
            check_field("scroll_req", want.scroll_req, data[25]);
            check_field("cursor_col_now", want.cursor_col_now, data[34:26]);
            check_field("cursor_row_now", want.cursor_row_now, data[42:35]);
            check_field("tdata padding", 0, data[47:43]);
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wen   = 1'b0;
    logic        i_cfg_index = CFG_NUM_COLS;
    logic [8:0]  i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    // tdata, lowest bit up: char_code[7:0], set_col[16:8], set_row[24:17], zero[31:25].
    logic [31:0] i_s_tdata   = '0;
    // tuser: mode[1:0].
    logic [1:0]  i_s_tuser   = MODE_CHAR;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b1;
    // tdata, lowest bit up: draw_valid, draw_col, draw_row, glyph_code, scroll_req,
    // cursor_col_now, cursor_row_now, zero padding.
    logic [47:0] o_m_tdata;

    // Idle bursts on the sending and the receiving side are switched on and off per stretch.
    bit sender_idles = 1'b0;
    bit sink_idles   = 1'b0;
    int cycle_count  = 0;

    cursor_scoreboard sb = new();

    text_console_cursor_engine_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The watchdog: a hung handshake or a lost result ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: every result transfer is checked against the oldest expectation, and
    // tready drops for random bursts while idling is on.
    initial begin : result_sink
        int stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata);
            end
            if (stall_left != 0) begin
                stall_left--;
            end else if (sink_idles && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            i_m_tready <= (stall_left == 0);
        end
    end

    // Offers one item and holds it until the block takes it. A random idle burst may come
    // first; tvalid is then lowered and raised again in different cycles.
    task automatic send_item(input logic [1:0] mode, input logic [7:0] code,
                             input logic [8:0] set_col, input logic [7:0] set_row);
        if (sender_idles && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {7'd0, set_row, set_col, code};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        sb.note_item(mode, code, set_col, set_row);
    endtask

    // Stops offering items and waits until every expected result has been checked, then
    // lets the two pipeline stages settle before any register is touched.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [8:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_reg(index, value);
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hand-picked items on the reset screen of 80 by 25: every glyph extreme, every control
    // code, ignored codes, save and restore, a wrap with scroll, and positions set far
    // beyond the screen.
    task automatic run_directed();
        send_item(MODE_CHAR, 8'd65, '0, '0);
        send_item(MODE_CHAR, CHAR_DEL, '0, '0);
        send_item(MODE_CHAR, CHAR_SPACE, '0, '0);
        send_item(MODE_CHAR, 8'd126, '0, '0);
        send_item(MODE_CHAR, CHAR_TAB, '0, '0);
        send_item(MODE_CHAR, CHAR_BS, '0, '0);
        send_item(MODE_CHAR, CHAR_CR, '0, '0);
        // Backspace at column zero does nothing at all.
        send_item(MODE_CHAR, CHAR_BS, '0, '0);
        send_item(MODE_CHAR, CHAR_LF, '0, '0);
        send_item(MODE_CHAR, 8'd0, '0, '0);
        send_item(MODE_CHAR, 8'd31, '0, '0);
        send_item(MODE_CHAR, 8'd128, '0, '0);
        send_item(MODE_CHAR, 8'd255, '0, '0);
        send_item(MODE_SAVE, '0, '0, '0);
        // The last cell of the screen: the glyph wraps the column and scrolls.
        send_item(MODE_SET, '0, 9'd79, 8'd24);
        send_item(MODE_CHAR, 8'd120, '0, '0);
        send_item(MODE_SET, '0, 9'd10, 8'd24);
        send_item(MODE_CHAR, CHAR_LF, '0, '0);
        // Off-screen cursor: a glyph is drawn there, then the position wraps and scrolls.
        send_item(MODE_SET, 8'hFF, 9'd511, 8'd255);
        send_item(MODE_CHAR, 8'd33, 9'd511, 8'd255);
        send_item(MODE_SET, '0, 9'd511, 8'd255);
        send_item(MODE_CHAR, CHAR_TAB, '0, '0);
        // Backspace off screen erases but neither wraps nor scrolls.
        send_item(MODE_SET, '0, 9'd511, 8'd255);
        send_item(MODE_CHAR, CHAR_BS, '0, '0);
        send_item(MODE_RESTORE, '0, '0, '0);
        send_item(MODE_CHAR, CHAR_CR, '0, '0);
    endtask

    // Random items, weighted toward printable glyphs and cursor control, with cursor
    // positions mostly on the screen, often at its edge, and sometimes anywhere.
    task automatic run_random(input int count, input bit idling);
        int unsigned ncols;
        int unsigned nrows;
        int          pick;
        logic [1:0]  mode;
        logic [7:0]  code;
        logic [8:0]  set_col;
        logic [7:0]  set_row;
        ncols = (sb.num_cols == 0) ? 1 : sb.num_cols;
        nrows = (sb.num_rows == 0) ? 1 : sb.num_rows;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                sender_idles = idling && ($urandom_range(0, 2) != 0);
                sink_idles   = idling && ($urandom_range(0, 2) != 0);
            end
            code    = 8'($urandom_range(0, 255));
            set_col = 9'($urandom_range(0, 511));
            set_row = 8'($urandom_range(0, 255));
            pick    = $urandom_range(0, 99);
            if (pick < 70) begin
                mode = MODE_CHAR;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: code = 8'($urandom_range(32, 127));
                    5: code = CHAR_LF;
                    6: code = CHAR_CR;
                    7: code = CHAR_TAB;
                    8: code = CHAR_BS;
                    default: ;
                endcase
            end else if (pick < 82) begin
                mode = MODE_SET;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        set_col = 9'($urandom_range(0, ncols - 1));
                        set_row = 8'($urandom_range(0, nrows - 1));
                    end
                    5, 6, 7: begin
                        set_col = (ncols > 3) ? 9'(ncols - $urandom_range(1, 3)) : '0;
                        set_row = (nrows > 2) ? 8'(nrows - $urandom_range(1, 2)) : '0;
                    end
                    default: ;
                endcase
            end else if (pick < 91) begin
                mode = MODE_SAVE;
            end else begin
                mode = MODE_RESTORE;
            end
            send_item(mode, code, set_col, set_row);
        end
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
    endtask

    // Main sequence: reset once, then a series of screen sizes, each written while the
    // block is idle, with the smallest, the largest and the zero size among them.
    initial begin : main_sequence
        logic [8:0] cols_list [7];
        logic [7:0] rows_list [7];
        cols_list = '{9'd80, 9'd0, 9'd1, 9'd511, 9'd4, 9'd0, 9'd7};
        rows_list = '{8'd25, 8'd0, 8'd1, 8'd255, 8'd3, 8'd0, 8'd5};
        cols_list[5] = 9'($urandom_range(1, 511));
        rows_list[5] = 8'($urandom_range(1, 255));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 7; phase++) begin
            drain();
            write_reg(CFG_NUM_COLS, cols_list[phase]);
            write_reg(CFG_NUM_ROWS, {1'b0, rows_list[phase]});
            if (phase == 0) begin
                run_directed();
            end
            // The last phase runs without any idling on either side.
            run_random(ITEMS_PER_PHASE, phase != 6);
        end

        drain();
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
